// File: rtl/lre_pkg.sv
// Shared constants and types for the line raster engine.
package lre_pkg;

  // Item command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Framebuffer layout: 1024 bytes per row, 2 bytes per pixel.
  localparam int ADDR_W    = 32;
  localparam int COLOUR_W  = 16;
  localparam int ROW_SHIFT = 10;
  localparam int COL_SHIFT = 1;

  // Orientation of the line that is loaded.
  typedef struct packed {
    logic steep;
    logic minor_down;
  } line_flags_t;

  // Outcome of one pixel step.
  typedef struct packed {
    logic last;
    logic minor_step;
  } step_flags_t;

endpackage

// File: rtl/lre_setup.sv
// Line setup: major axis choice, endpoint ordering, deltas and initial error.
module lre_setup import lre_pkg::*; #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8,
  parameter int C_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS,
  parameter int E_BITS = C_BITS + 2
) (
  input  logic [X_BITS-1:0]        start_x,
  input  logic [Y_BITS-1:0]        start_y,
  input  logic [X_BITS-1:0]        end_x,
  input  logic [Y_BITS-1:0]        end_y,
  output line_flags_t              flags,
  output logic [C_BITS-1:0]        major_pos,
  output logic [C_BITS-1:0]        major_end,
  output logic [C_BITS-1:0]        minor_pos,
  output logic [C_BITS-1:0]        major_delta,
  output logic [C_BITS-1:0]        minor_delta,
  output logic signed [E_BITS-1:0] error_init
);

  logic [C_BITS-1:0] x0, y0, x1, y1;
  logic [C_BITS-1:0] dx, dy;
  logic [C_BITS-1:0] a0, b0, a1, b1;
  logic [C_BITS-1:0] lo_a, lo_b, hi_a, hi_b;
  logic              steep;

  // Widen the endpoints to the common coordinate width.
  assign x0 = C_BITS'(start_x);
  assign y0 = C_BITS'(start_y);
  assign x1 = C_BITS'(end_x);
  assign y1 = C_BITS'(end_y);

  // The line is steep when it spans more rows than columns.
  assign dx    = (x1 > x0) ? (x1 - x0) : (x0 - x1);
  assign dy    = (y1 > y0) ? (y1 - y0) : (y0 - y1);
  assign steep = dy > dx;

  // Map onto major and minor axes.
  assign a0 = steep ? y0 : x0;
  assign b0 = steep ? x0 : y0;
  assign a1 = steep ? y1 : x1;
  assign b1 = steep ? x1 : y1;

  // Order the endpoints so the major coordinate rises.
  always_comb begin
    if (a0 > a1) begin
      lo_a = a1;
      lo_b = b1;
      hi_a = a0;
      hi_b = b0;
    end else begin
      lo_a = a0;
      lo_b = b0;
      hi_a = a1;
      hi_b = b1;
    end
  end

  assign major_pos   = lo_a;
  assign major_end   = hi_a;
  assign minor_pos   = lo_b;
  assign major_delta = hi_a - lo_a;
  assign minor_delta = (hi_b > lo_b) ? (hi_b - lo_b) : (lo_b - hi_b);

  assign flags.steep      = steep;
  assign flags.minor_down = !(lo_b < hi_b);

  // The error term starts at minus half the major delta.
  assign error_init = E_BITS'(0) - $signed(E_BITS'(major_delta >> 1));

endmodule

// File: rtl/lre_step.sv
// Pixel step: plotted coordinates, byte address and the next Bresenham state.
module lre_step import lre_pkg::*; #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8,
  parameter int C_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS,
  parameter int E_BITS = C_BITS + 2
) (
  input  line_flags_t              flags,
  input  logic [C_BITS-1:0]        major_pos,
  input  logic [C_BITS-1:0]        major_end,
  input  logic [C_BITS-1:0]        minor_pos,
  input  logic [C_BITS-1:0]        major_delta,
  input  logic [C_BITS-1:0]        minor_delta,
  input  logic signed [E_BITS-1:0] error_term,
  input  logic [ADDR_W-1:0]        frame_base,
  output logic [X_BITS-1:0]        pixel_x,
  output logic [Y_BITS-1:0]        pixel_y,
  output logic [ADDR_W-1:0]        pixel_address,
  output step_flags_t              status,
  output logic [C_BITS-1:0]        major_pos_nxt,
  output logic [C_BITS-1:0]        minor_pos_nxt,
  output logic signed [E_BITS-1:0] error_nxt
);

  logic [C_BITS-1:0]        col, row;
  logic signed [E_BITS-1:0] err_sum;

  // Pick the plotted coordinates from the major and minor positions.
  assign col     = flags.steep ? minor_pos : major_pos;
  assign row     = flags.steep ? major_pos : minor_pos;
  assign pixel_x = col[X_BITS-1:0];
  assign pixel_y = row[Y_BITS-1:0];

  // Byte address of the pixel, wrapping at the address width.
  assign pixel_address = frame_base + (ADDR_W'(pixel_y) << ROW_SHIFT)
                       + (ADDR_W'(pixel_x) << COL_SHIFT);

  // Accumulate the minor delta; a positive error moves the minor axis.
  assign err_sum           = error_term + $signed(E_BITS'(minor_delta));
  assign status.minor_step = err_sum > $signed(E_BITS'(0));
  assign status.last       = major_pos == major_end;

  always_comb begin
    error_nxt     = err_sum;
    minor_pos_nxt = minor_pos;
    if (status.minor_step) begin
      error_nxt     = err_sum - $signed(E_BITS'(major_delta));
      minor_pos_nxt = flags.minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
    end
  end

  // The major position holds on the final pixel.
  assign major_pos_nxt = status.last ? major_pos : (major_pos + 1'b1);

endmodule

// File: rtl/line_raster_engine.sv
// Top level of the line raster engine: item register, line state and result register.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    cmd, endpoints, color
//   out_     output     out_valid / out_stall  pixel x, y, color, address, last flag
//   cfg_     input      cfg_valid / cfg_ready  frame base address
//
// An item is registered on entry and executed from the item register, and a
// tick's pixel is then registered in the result register; one item per cycle
// is sustained while no pixel-making tick waits on out_stall, set by the error
// and position update loop.
// Start items and idle ticks execute even while a result waits on out_stall;
// only a tick that makes a pixel waits for the result register.
// Reset (synchronous, rst_n low) empties both registers, leaves the block
// idle and clears the frame base. cfg_ready is always high.
module line_raster_engine import lre_pkg::*; #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [X_BITS-1:0]   in_start_x,
  input  logic [Y_BITS-1:0]   in_start_y,
  input  logic [X_BITS-1:0]   in_end_x,
  input  logic [Y_BITS-1:0]   in_end_y,
  input  logic [COLOUR_W-1:0] in_colour_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [X_BITS-1:0]   out_pixel_x,
  output logic [Y_BITS-1:0]   out_pixel_y,
  output logic [COLOUR_W-1:0] out_pixel_colour,
  output logic [ADDR_W-1:0]   out_pixel_address,
  output logic                out_last_pixel,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ADDR_W-1:0]   cfg_data
);

  localparam int C_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int E_BITS = C_BITS + 2;

  // Item register.
  logic                in_full_r;
  logic                cmd_r;
  logic [X_BITS-1:0]   start_x_r, end_x_r;
  logic [Y_BITS-1:0]   start_y_r, end_y_r;
  logic [COLOUR_W-1:0] colour_r;

  // Line state.
  logic                     drawing_r;
  line_flags_t              flags_r;
  logic [C_BITS-1:0]        major_pos_r, major_end_r, minor_pos_r;
  logic [C_BITS-1:0]        major_delta_r, minor_delta_r;
  logic signed [E_BITS-1:0] error_r;
  logic [COLOUR_W-1:0]      draw_colour_r;
  logic [ADDR_W-1:0]        frame_base_r;

  // Result register.
  logic                out_valid_r;
  logic [X_BITS-1:0]   pixel_x_r;
  logic [Y_BITS-1:0]   pixel_y_r;
  logic [COLOUR_W-1:0] pixel_colour_r;
  logic [ADDR_W-1:0]   pixel_address_r;
  logic                last_pixel_r;

  // Setup and step results.
  line_flags_t              set_flags;
  logic [C_BITS-1:0]        set_major_pos, set_major_end, set_minor_pos;
  logic [C_BITS-1:0]        set_major_delta, set_minor_delta;
  logic signed [E_BITS-1:0] set_error;
  logic [X_BITS-1:0]        stp_x;
  logic [Y_BITS-1:0]        stp_y;
  logic [ADDR_W-1:0]        stp_address;
  step_flags_t              stp_status;
  logic [C_BITS-1:0]        major_pos_nxt, minor_pos_nxt;
  logic signed [E_BITS-1:0] error_nxt;

  logic is_start, is_pixel, exec_go, in_take;

  lre_setup #(.X_BITS(X_BITS), .Y_BITS(Y_BITS)) u_setup (
    .start_x     (start_x_r),
    .start_y     (start_y_r),
    .end_x       (end_x_r),
    .end_y       (end_y_r),
    .flags       (set_flags),
    .major_pos   (set_major_pos),
    .major_end   (set_major_end),
    .minor_pos   (set_minor_pos),
    .major_delta (set_major_delta),
    .minor_delta (set_minor_delta),
    .error_init  (set_error)
  );

  lre_step #(.X_BITS(X_BITS), .Y_BITS(Y_BITS)) u_step (
    .flags         (flags_r),
    .major_pos     (major_pos_r),
    .major_end     (major_end_r),
    .minor_pos     (minor_pos_r),
    .major_delta   (major_delta_r),
    .minor_delta   (minor_delta_r),
    .error_term    (error_r),
    .frame_base    (frame_base_r),
    .pixel_x       (stp_x),
    .pixel_y       (stp_y),
    .pixel_address (stp_address),
    .status        (stp_status),
    .major_pos_nxt (major_pos_nxt),
    .minor_pos_nxt (minor_pos_nxt),
    .error_nxt     (error_nxt)
  );

  // Only a tick on a line in progress needs room in the result register.
  assign is_start = in_full_r && (cmd_r == CMD_START);
  assign is_pixel = in_full_r && (cmd_r == CMD_TICK) && drawing_r;
  assign exec_go  = in_full_r && !(is_pixel && out_valid_r && out_stall);
  assign in_stall = in_full_r && !exec_go;
  assign in_take  = in_valid && !in_stall;

  // Item register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_take) begin
      in_full_r <= 1'b1;
    end else if (exec_go) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r     <= in_cmd;
      start_x_r <= in_start_x;
      start_y_r <= in_start_y;
      end_x_r   <= in_end_x;
      end_y_r   <= in_end_y;
      colour_r  <= in_colour_in;
    end
  end

  // Line state: loaded by a start item, advanced by each plotted pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drawing_r     <= 1'b0;
      flags_r       <= '0;
      major_pos_r   <= '0;
      major_end_r   <= '0;
      minor_pos_r   <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      error_r       <= '0;
      draw_colour_r <= '0;
    end else if (exec_go && is_start) begin
      drawing_r     <= 1'b1;
      flags_r       <= set_flags;
      major_pos_r   <= set_major_pos;
      major_end_r   <= set_major_end;
      minor_pos_r   <= set_minor_pos;
      major_delta_r <= set_major_delta;
      minor_delta_r <= set_minor_delta;
      error_r       <= set_error;
      draw_colour_r <= colour_r;
    end else if (exec_go && is_pixel) begin
      drawing_r   <= !stp_status.last;
      major_pos_r <= major_pos_nxt;
      minor_pos_r <= minor_pos_nxt;
      error_r     <= error_nxt;
    end
  end

  // Frame base register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frame_base_r <= cfg_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go && is_pixel) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && is_pixel) begin
      pixel_x_r       <= stp_x;
      pixel_y_r       <= stp_y;
      pixel_colour_r  <= draw_colour_r;
      pixel_address_r <= stp_address;
      last_pixel_r    <= stp_status.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = pixel_x_r;
  assign out_pixel_y       = pixel_y_r;
  assign out_pixel_colour  = pixel_colour_r;
  assign out_pixel_address = pixel_address_r;
  assign out_last_pixel    = last_pixel_r;

endmodule

// File: rtl/lre_checker.sv
// Port-level assertions for the line raster engine and the bind that attaches them.
module lre_checker import lre_pkg::*; #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [X_BITS-1:0]   out_pixel_x,
  input logic [Y_BITS-1:0]   out_pixel_y,
  input logic [COLOUR_W-1:0] out_pixel_colour,
  input logic [ADDR_W-1:0]   out_pixel_address,
  input logic                out_last_pixel,
  input logic                cfg_ready
);

  // A stalled result keeps its pixel.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_pixel_colour) && $stable(out_pixel_address)
      && $stable(out_last_pixel))
    else $error("stalled result changed");

  // Input stalls only while a result is held back by the output side.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending after reset");

  // The frame base register never refuses a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind line_raster_engine lre_checker #(.X_BITS(X_BITS), .Y_BITS(Y_BITS)) u_lre_checker (.*);
